// File: design/tfpac_pkg.sv
// ----------------------------------------------------------------------------
// tfpac_pkg
// Shared types and constants of the tank fill, pump and alarm controller.
// ----------------------------------------------------------------------------
package tfpac_pkg;

  // stream widths
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // tank level states
  localparam logic [1:0] MODE_LOW    = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_FULL   = 2'd2;

  // beeper toggle period
  localparam logic [31:0] BEEP_PERIOD_MS = 32'd500;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRY_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TANK_LOW_ENTER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TANK_LOW_EXIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TANK_FULL_ENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TANK_FULL_EXIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_TIMEOUT_MS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS   = 3'd7;

  // configuration set
  typedef struct packed {
    logic [11:0] dry_threshold;
    logic [11:0] tank_low_enter;
    logic [11:0] tank_low_exit;
    logic [11:0] tank_full_enter;
    logic [11:0] tank_full_exit;
    logic [31:0] fill_timeout_ms;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  // one control-loop sample
  typedef struct packed {
    logic        alarm_button_pressed;
    logic        button_b_pressed;
    logic        button_a_pressed;
    logic        sensor_ok;
    logic        rain;
    logic [11:0] tank_level;
    logic [11:0] soil_b;
    logic [11:0] soil_a;
    logic [31:0] now_ms;
  } item_t;

  // one result word
  typedef struct packed {
    logic       manual_b_on;
    logic       manual_a_on;
    logic [1:0] level_state;
    logic       fault_flag;
    logic       beeper_on;
    logic       valve_is_open;
    logic       pump_b_on;
    logic       pump_a_on;
  } res_t;

endpackage

// File: design/tfpac_cfg.sv
// ----------------------------------------------------------------------------
// tfpac_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tfpac_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tfpac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfpac_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output tfpac_pkg::cfg_t                     cfg
);
  import tfpac_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DRY_THRESHOLD:   cfg_nxt.dry_threshold   = cfg_wdata[11:0];
        REG_TANK_LOW_ENTER:  cfg_nxt.tank_low_enter  = cfg_wdata[11:0];
        REG_TANK_LOW_EXIT:   cfg_nxt.tank_low_exit   = cfg_wdata[11:0];
        REG_TANK_FULL_ENTER: cfg_nxt.tank_full_enter = cfg_wdata[11:0];
        REG_TANK_FULL_EXIT:  cfg_nxt.tank_full_exit  = cfg_wdata[11:0];
        REG_FILL_TIMEOUT_MS: cfg_nxt.fill_timeout_ms = cfg_wdata[31:0];
        REG_DEBOUNCE_MS:     cfg_nxt.debounce_ms     = cfg_wdata[15:0];
        REG_LONG_PRESS_MS:   cfg_nxt.long_press_ms   = cfg_wdata[15:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  // registers with reset defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dry_threshold   <= 12'd2500;
      cfg_r.tank_low_enter  <= 12'd1000;
      cfg_r.tank_low_exit   <= 12'd1200;
      cfg_r.tank_full_enter <= 12'd3000;
      cfg_r.tank_full_exit  <= 12'd2800;
      cfg_r.fill_timeout_ms <= 32'd60000;
      cfg_r.debounce_ms     <= 16'd50;
      cfg_r.long_press_ms   <= 16'd2000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/tfpac_step.sv
// ----------------------------------------------------------------------------
// tfpac_step
// Controller state and the single-pass update logic for one sample.
// ----------------------------------------------------------------------------
module tfpac_step (
  input  logic               clk,
  input  logic               rst_n,
  input  tfpac_pkg::cfg_t    cfg,
  input  logic               step_en,
  input  tfpac_pkg::item_t   item,
  output tfpac_pkg::res_t    res
);
  import tfpac_pkg::*;

  // controller state
  logic [1:0]       mode_r,    mode_nxt;
  logic             valve_r,   valve_nxt;
  logic [31:0]      vstamp_r,  vstamp_nxt;
  logic             fault_r,   fault_nxt;
  logic [1:0]       manual_r,  manual_nxt;
  logic [2:0]       prev_r,    prev_nxt;
  logic [2:0][31:0] pstamp_r,  pstamp_nxt;
  logic [1:0]       handled_r, handled_nxt;
  logic             sil_r,     sil_nxt;
  logic             beep_r,    beep_nxt;
  logic [31:0]      bstamp_r,  bstamp_nxt;
  logic             psf_r,     psf_nxt;

  logic low;
  logic full;
  logic warning;
  logic pump_a;
  logic pump_b;
  logic [2:0] btn;

  assign btn = {item.alarm_button_pressed, item.button_b_pressed, item.button_a_pressed};

  // next-state logic for one sample
  always_comb begin
    logic        vstamp_now;
    logic [31:0] open_time;
    logic [31:0] held;
    logic [31:0] dur;
    logic [31:0] since_beep;
    logic        rise;
    logic        bstamp_now;

    mode_nxt    = mode_r;
    valve_nxt   = valve_r;
    vstamp_nxt  = vstamp_r;
    fault_nxt   = fault_r;
    manual_nxt  = manual_r;
    pstamp_nxt  = pstamp_r;
    handled_nxt = handled_r;
    sil_nxt     = sil_r;
    beep_nxt    = beep_r;
    bstamp_nxt  = bstamp_r;
    psf_nxt     = psf_r;
    prev_nxt    = btn;
    vstamp_now  = 1'b0;
    bstamp_now  = 1'b0;

    // level hysteresis
    case (mode_r)
      MODE_LOW: begin
        if (item.tank_level >= cfg.tank_full_enter) mode_nxt = MODE_FULL;
        else if (item.tank_level >= cfg.tank_low_exit) mode_nxt = MODE_NORMAL;
      end
      MODE_FULL: begin
        if (item.tank_level < cfg.tank_low_enter) mode_nxt = MODE_LOW;
        else if (item.tank_level < cfg.tank_full_exit) mode_nxt = MODE_NORMAL;
      end
      default: begin
        if (item.tank_level < cfg.tank_low_enter) mode_nxt = MODE_LOW;
        else if (item.tank_level >= cfg.tank_full_enter) mode_nxt = MODE_FULL;
        else mode_nxt = MODE_NORMAL;
      end
    endcase
    low  = (mode_nxt == MODE_LOW);
    full = (mode_nxt == MODE_FULL);

    // entering low clears fault and silence, opens the valve
    if (low && mode_r != MODE_LOW) begin
      sil_nxt   = 1'b0;
      fault_nxt = 1'b0;
      if (!valve_nxt) begin
        valve_nxt  = 1'b1;
        vstamp_now = 1'b1;
      end
    end
    if (low && !valve_nxt && !fault_nxt) begin
      valve_nxt  = 1'b1;
      vstamp_now = 1'b1;
    end
    if (full) begin
      valve_nxt = 1'b0;
      fault_nxt = 1'b0;
      sil_nxt   = 1'b0;
    end

    // fill timeout, a valve opened now has been open for zero ms
    open_time = vstamp_now ? 32'd0 : item.now_ms - vstamp_r;
    if (vstamp_now) vstamp_nxt = item.now_ms;
    if (valve_nxt && !full && !fault_nxt && open_time >= cfg.fill_timeout_ms) begin
      valve_nxt = 1'b0;
      fault_nxt = 1'b1;
      sil_nxt   = 1'b0;
    end

    // manual buttons with debounce
    for (int k = 0; k < 2; k++) begin
      rise = !prev_r[k] && btn[k];
      held = rise ? 32'd0 : item.now_ms - pstamp_r[k];
      if (rise) begin
        pstamp_nxt[k]  = item.now_ms;
        handled_nxt[k] = 1'b0;
      end
      if (btn[k] && !handled_nxt[k] && held >= {16'd0, cfg.debounce_ms}) begin
        manual_nxt[k]  = !manual_r[k];
        handled_nxt[k] = 1'b1;
      end
    end

    // alarm button, measured on release
    if (!prev_r[2] && btn[2]) pstamp_nxt[2] = item.now_ms;
    dur = item.now_ms - pstamp_r[2];
    if (prev_r[2] && !btn[2]) begin
      if (dur >= {16'd0, cfg.long_press_ms}) begin
        if (fault_nxt) begin
          fault_nxt = 1'b0;
          sil_nxt   = 1'b0;
          if (low && !valve_nxt) begin
            valve_nxt  = 1'b1;
            vstamp_nxt = item.now_ms;
          end
        end else if (low || !item.sensor_ok) begin
          sil_nxt = 1'b0;
        end
      end else if (dur >= {16'd0, cfg.debounce_ms}) begin
        if (fault_nxt || low || !item.sensor_ok) sil_nxt = 1'b1;
      end
    end

    // pump drive with interlock
    if (low || fault_nxt) begin
      pump_a = 1'b0;
      pump_b = 1'b0;
    end else begin
      pump_a = manual_nxt[0] || (!item.rain && item.soil_a >= cfg.dry_threshold);
      pump_b = manual_nxt[1] || (!item.rain && item.soil_b >= cfg.dry_threshold);
    end

    // beeper cadence
    warning = fault_nxt || low || !item.sensor_ok;
    if (!warning) begin
      beep_nxt = 1'b0;
      sil_nxt  = 1'b0;
    end else begin
      if (!item.sensor_ok && !psf_r) begin
        sil_nxt    = 1'b0;
        bstamp_now = 1'b1;
        bstamp_nxt = item.now_ms;
      end
      psf_nxt    = !item.sensor_ok;
      since_beep = bstamp_now ? 32'd0 : item.now_ms - bstamp_r;
      if (sil_nxt) begin
        beep_nxt = 1'b0;
      end else if (since_beep >= BEEP_PERIOD_MS) begin
        bstamp_nxt = item.now_ms;
        beep_nxt   = !beep_r;
      end
    end
  end

  // result fields
  always_comb begin
    res.pump_a_on     = pump_a;
    res.pump_b_on     = pump_b;
    res.valve_is_open = valve_nxt;
    res.beeper_on     = beep_nxt;
    res.fault_flag    = fault_nxt;
    res.level_state   = mode_nxt;
    res.manual_a_on   = manual_nxt[0];
    res.manual_b_on   = manual_nxt[1];
  end

  // state update, one sample per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      valve_r   <= 1'b0;
      vstamp_r  <= 32'd0;
      fault_r   <= 1'b0;
      manual_r  <= 2'b00;
      prev_r    <= 3'b000;
      pstamp_r  <= '0;
      handled_r <= 2'b00;
      sil_r     <= 1'b0;
      beep_r    <= 1'b0;
      bstamp_r  <= 32'd0;
      psf_r     <= 1'b0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      valve_r   <= valve_nxt;
      vstamp_r  <= vstamp_nxt;
      fault_r   <= fault_nxt;
      manual_r  <= manual_nxt;
      prev_r    <= prev_nxt;
      pstamp_r  <= pstamp_nxt;
      handled_r <= handled_nxt;
      sil_r     <= sil_nxt;
      beep_r    <= beep_nxt;
      bstamp_r  <= bstamp_nxt;
      psf_r     <= psf_nxt;
    end
  end

endmodule

// File: design/tank_fill_pump_alarm_controller.sv
// ----------------------------------------------------------------------------
// tank_fill_pump_alarm_controller
// Tank level hysteresis, fill valve with timeout fault, debounced manual pump
// buttons, alarm silence and fault clear button, pump interlock and beeper.
//
//   channel  direction  handshake          payload
//   in_      slave      tvalid / tready    tdata: one control-loop sample
//   out_     master     tvalid / tready    tdata: one result word
//   cfg_     write      we                 index, wdata
//
// One result per sample, a new sample accepted every cycle unless the output
// stalls. Samples pass through an input register, then the update logic
// feeding the output register; the state loop closes through tfpac_step.
// A stalled output holds its word; the input register still takes one more
// sample while the output waits. Reset is synchronous, active low, and puts
// the tank state at normal and the config, state and valid registers at their defaults.
// ----------------------------------------------------------------------------
module tank_fill_pump_alarm_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // now_ms[31:0], soil_a[43:32], soil_b[55:44], tank_level[67:56], rain[68],
  // sensor_ok[69], button_a_pressed[70], button_b_pressed[71],
  // alarm_button_pressed[72], zero fill [79:73]
  input  logic [tfpac_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // pump_a_on[0], pump_b_on[1], valve_is_open[2], beeper_on[3], fault_flag[4],
  // level_state[6:5], manual_a_on[7], manual_b_on[8], zero fill [15:9]
  output logic [tfpac_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [tfpac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfpac_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tfpac_pkg::*;

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned RES_W  = $bits(res_t);

  cfg_t  cfg;
  item_t in_item_r, in_item_nxt;
  logic  in_valid_r, in_valid_nxt;
  res_t  res;
  res_t  out_res_r, out_res_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  advance;

  // configuration registers
  tfpac_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // update logic and controller state
  tfpac_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (advance),
    .item    (in_item_r),
    .res     (res)
  );

  // handshake between the two register stages
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_item_nxt   = in_item_r;
    in_valid_nxt  = in_valid_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (advance) begin
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
      in_valid_nxt  = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      in_item_nxt  = item_t'(in_tdata[ITEM_W-1:0]);
      in_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_res_r};

`ifndef ASSERT_OFF
  // pumps are interlocked off while low or faulted
  a_pump_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.fault_flag || out_res_r.level_state == MODE_LOW)
      |-> !out_res_r.pump_a_on && !out_res_r.pump_b_on)
    else $error("pump driven while tank low or fill fault latched");

  // a latched fault or a full tank always closes the valve
  a_valve_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.fault_flag || out_res_r.level_state == MODE_FULL)
      |-> !out_res_r.valve_is_open)
    else $error("valve open with fault latched or tank full");

  // the tank state code stays within low, normal and full
  a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.level_state != 2'd3)
    else $error("undefined tank state code");

  // a stalled output with a held sample blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_tready |-> !in_tready && !advance)
    else $error("sample taken while both stages are stalled");
`endif

endmodule

// File: verif/tb_tank_fill_pump_alarm_controller.sv
// ----------------------------------------------------------------------------
// tb_tank_fill_pump_alarm_controller
// Streams control-loop samples into the tank fill, pump and alarm controller
// and checks every result word against a cycle-free predictor of the control
// step. The run covers the reset defaults and several register settings:
// the all-max and all-zero extremes, crossed level thresholds, a zero fill
// timeout and a long press shorter than the debounce time. Samples follow a
// walking tank level, held button levels and mixed time steps with wraps.
// The sender idles in bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb_tank_fill_pump_alarm_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import tfpac_pkg::*;

  // clock, reset and block ports
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  // now_ms[31:0], soil_a[43:32], soil_b[55:44], tank_level[67:56], rain[68],
  // sensor_ok[69], button_a_pressed[70], button_b_pressed[71],
  // alarm_button_pressed[72], zero fill [79:73]
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // pump_a_on[0], pump_b_on[1], valve_is_open[2], beeper_on[3], fault_flag[4],
  // level_state[6:5], manual_a_on[7], manual_b_on[8], zero fill [15:9]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  tank_fill_pump_alarm_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // samples waiting to be sent, result words still to come
  item_t sample_q[$];
  res_t  expected_words[$];
  int    open_samples = 0;
  int    mismatches   = 0;

  // predictor copy of the settings and the controller state
  cfg_t        set_now;
  logic [1:0]  tank_st;
  bit          valve_on;
  logic [31:0] valve_start_ms;
  bit          fault_latched;
  bit          manual_on [2];
  bit          btn_last [3];
  logic [31:0] press_start_ms [3];
  bit          press_done [2];
  bit          silenced;
  bit          beep;
  logic [31:0] beep_start_ms;
  bit          sensor_fault_last;

  // stimulus walk state
  logic [31:0] walk_ms;
  int          walk_level;
  bit          walk_up;
  bit          walk_btn_a, walk_btn_b, walk_btn_alarm, walk_ok;

  // sender burst and receiver stall state
  int          burst_left = 1;
  int          gap_left   = 0;
  logic [15:0] stall_pat  = 16'hffff;

  task automatic open_valve(input logic [31:0] now);
    if (!valve_on) begin
      valve_on       = 1'b1;
      valve_start_ms = now;
    end
  endtask

  // one control step: level hysteresis, valve, buttons, pumps, beeper
  task automatic control_step(input item_t s, output res_t r);
    logic [1:0]  prev_st;
    logic [31:0] held_ms;
    bit          low, warn, cur;
    int          k;
    prev_st = tank_st;
    case (tank_st)
      MODE_LOW: begin
        if (s.tank_level >= set_now.tank_full_enter) tank_st = MODE_FULL;
        else if (s.tank_level >= set_now.tank_low_exit) tank_st = MODE_NORMAL;
      end
      MODE_FULL: begin
        if (s.tank_level < set_now.tank_low_enter) tank_st = MODE_LOW;
        else if (s.tank_level < set_now.tank_full_exit) tank_st = MODE_NORMAL;
      end
      default: begin
        if (s.tank_level < set_now.tank_low_enter) tank_st = MODE_LOW;
        else if (s.tank_level >= set_now.tank_full_enter) tank_st = MODE_FULL;
        else tank_st = MODE_NORMAL;
      end
    endcase
    low = (tank_st == MODE_LOW);

    // fill valve and timeout fault
    if (low && prev_st != MODE_LOW) begin
      silenced      = 1'b0;
      fault_latched = 1'b0;
      open_valve(s.now_ms);
    end
    if (low && !valve_on && !fault_latched) open_valve(s.now_ms);
    if (tank_st == MODE_FULL) begin
      valve_on      = 1'b0;
      fault_latched = 1'b0;
      silenced      = 1'b0;
    end
    held_ms = s.now_ms - valve_start_ms;
    if (valve_on && tank_st != MODE_FULL && !fault_latched &&
        held_ms >= set_now.fill_timeout_ms) begin
      valve_on      = 1'b0;
      fault_latched = 1'b1;
      silenced      = 1'b0;
    end

    // manual pump buttons toggle once per debounced press
    for (k = 0; k < 2; k++) begin
      cur = (k == 0) ? s.button_a_pressed : s.button_b_pressed;
      if (!btn_last[k] && cur) begin
        press_start_ms[k] = s.now_ms;
        press_done[k]     = 1'b0;
      end
      held_ms = s.now_ms - press_start_ms[k];
      if (cur && !press_done[k] && held_ms >= {16'd0, set_now.debounce_ms}) begin
        manual_on[k]  = !manual_on[k];
        press_done[k] = 1'b1;
      end
      btn_last[k] = cur;
    end

    // alarm button acts on release, long press checked first
    if (!btn_last[2] && s.alarm_button_pressed) press_start_ms[2] = s.now_ms;
    if (btn_last[2] && !s.alarm_button_pressed) begin
      held_ms = s.now_ms - press_start_ms[2];
      if (held_ms >= {16'd0, set_now.long_press_ms}) begin
        if (fault_latched) begin
          fault_latched = 1'b0;
          silenced      = 1'b0;
          if (low) open_valve(s.now_ms);
        end else if (low || !s.sensor_ok) begin
          silenced = 1'b0;
        end
      end else if (held_ms >= {16'd0, set_now.debounce_ms}) begin
        if (fault_latched || low || !s.sensor_ok) silenced = 1'b1;
      end
    end
    btn_last[2] = s.alarm_button_pressed;

    // pump interlock
    if (low || fault_latched) begin
      r.pump_a_on = 1'b0;
      r.pump_b_on = 1'b0;
    end else begin
      r.pump_a_on = manual_on[0] ||
                    (!s.rain && s.soil_a >= set_now.dry_threshold);
      r.pump_b_on = manual_on[1] ||
                    (!s.rain && s.soil_b >= set_now.dry_threshold);
    end

    // beeper toggles while a warning is active and not silenced
    warn = fault_latched || low || !s.sensor_ok;
    if (!warn) begin
      beep     = 1'b0;
      silenced = 1'b0;
    end else begin
      if (!s.sensor_ok && !sensor_fault_last) begin
        silenced      = 1'b0;
        beep_start_ms = s.now_ms;
      end
      sensor_fault_last = !s.sensor_ok;
      held_ms = s.now_ms - beep_start_ms;
      if (silenced) begin
        beep = 1'b0;
      end else if (held_ms >= BEEP_PERIOD_MS) begin
        beep_start_ms = s.now_ms;
        beep          = !beep;
      end
    end

    r.valve_is_open = valve_on;
    r.beeper_on     = beep;
    r.fault_flag    = fault_latched;
    r.level_state   = tank_st;
    r.manual_a_on   = manual_on[0];
    r.manual_b_on   = manual_on[1];
  endtask

  task automatic add_sample(input logic [31:0] now, input int sa, input int sb,
                            input int lvl, input bit rain, input bit ok,
                            input bit ba, input bit bb, input bit bal);
    item_t s;
    s.now_ms               = now;
    s.soil_a               = sa[11:0];
    s.soil_b               = sb[11:0];
    s.tank_level           = lvl[11:0];
    s.rain                 = rain;
    s.sensor_ok            = ok;
    s.button_a_pressed     = ba;
    s.button_b_pressed     = bb;
    s.alarm_button_pressed = bal;
    sample_q.push_back(s);
    open_samples++;
  endtask

  // random samples: walking level, held buttons, mixed time steps
  task automatic add_random_samples(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0:       walk_ms = $urandom();
        1, 2, 3: walk_ms = walk_ms + $urandom_range(0, 4000);
        default: walk_ms = walk_ms + $urandom_range(0, 200);
      endcase
      if ($urandom_range(0, 9) == 0) walk_up = !walk_up;
      if ($urandom_range(0, 11) == 0) walk_level = $urandom_range(0, 4095);
      else if (walk_up) walk_level = walk_level + $urandom_range(0, 250);
      else walk_level = walk_level - $urandom_range(0, 250);
      if (walk_level < 0) walk_level = 0;
      if (walk_level > 4095) walk_level = 4095;
      if ($urandom_range(0, 3) == 0) walk_btn_a = !walk_btn_a;
      if ($urandom_range(0, 3) == 0) walk_btn_b = !walk_btn_b;
      if ($urandom_range(0, 4) == 0) walk_btn_alarm = !walk_btn_alarm;
      if ($urandom_range(0, 9) == 0) walk_ok = !walk_ok;
      add_sample(walk_ms, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 walk_level, $urandom_range(0, 2) == 0, walk_ok,
                 walk_btn_a, walk_btn_b, walk_btn_alarm);
    end
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // write all registers, optionally with noise above the narrow fields
  task automatic apply_settings(input cfg_t s, input bit noisy);
    logic [31:0] nz;
    nz = noisy ? $urandom() : 32'd0;
    put_reg(REG_DRY_THRESHOLD,   {nz[31:12], s.dry_threshold});
    put_reg(REG_TANK_LOW_ENTER,  {nz[31:12], s.tank_low_enter});
    put_reg(REG_TANK_LOW_EXIT,   {nz[31:12], s.tank_low_exit});
    put_reg(REG_TANK_FULL_ENTER, {nz[31:12], s.tank_full_enter});
    put_reg(REG_TANK_FULL_EXIT,  {nz[31:12], s.tank_full_exit});
    put_reg(REG_FILL_TIMEOUT_MS, s.fill_timeout_ms);
    put_reg(REG_DEBOUNCE_MS,     {nz[31:16], s.debounce_ms});
    put_reg(REG_LONG_PRESS_MS,   {nz[31:16], s.long_press_ms});
    @(posedge clk);
    cfg_we  <= 1'b0;
    set_now = s;
  endtask

  // wait until every result has come back, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk); while (open_samples != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.dry_threshold   = 12'($urandom_range(0, 4095));
    s.tank_low_enter  = 12'($urandom_range(200, 1500));
    s.tank_low_exit   = s.tank_low_enter + 12'($urandom_range(0, 400));
    s.tank_full_enter = 12'($urandom_range(2500, 3900));
    s.tank_full_exit  = s.tank_full_enter - 12'($urandom_range(0, 400));
    s.fill_timeout_ms = 32'($urandom_range(50, 3000));
    s.debounce_ms     = 16'($urandom_range(0, 150));
    s.long_press_ms   = 16'($urandom_range(200, 2500));
    return s;
  endfunction

  // sender: bursts of words with random gaps, prediction on acceptance
  always @(posedge clk) begin : drive_proc
    res_t want;
    bit   free;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      free = !in_tvalid || in_tready;
      if (in_tvalid && in_tready) begin
        control_step(item_t'(in_tdata[$bits(item_t)-1:0]), want);
        expected_words.push_back(want);
      end
      if (free) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_tdata  <= {{(IN_DATA_W - $bits(item_t)){1'b0}}, sample_q.pop_front()};
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver: rotating stall pattern, field by field compare
  always @(posedge clk) begin : sink_proc
    res_t        got, want;
    logic [15:0] pat;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[$bits(res_t)-1:0]);
      if (expected_words.size() == 0) begin
        $display("%0t ns: word expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("pump_a_on",     want.pump_a_on,     got.pump_a_on);
        check_field("pump_b_on",     want.pump_b_on,     got.pump_b_on);
        check_field("valve_is_open", want.valve_is_open, got.valve_is_open);
        check_field("beeper_on",     want.beeper_on,     got.beeper_on);
        check_field("fault_flag",    want.fault_flag,    got.fault_flag);
        check_field("level_state",   want.level_state,   got.level_state);
        check_field("manual_a_on",   want.manual_a_on,   got.manual_a_on);
        check_field("manual_b_on",   want.manual_b_on,   got.manual_b_on);
        open_samples--;
      end
    end
    pat = {stall_pat[0], stall_pat[15:1]};
    if ($urandom_range(0, 63) == 0)
      pat = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom());
    stall_pat  <= pat;
    out_tready <= stall_pat[0];
  end

  // run watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // main sequence
  initial begin
    set_now           = '{12'd2500, 12'd1000, 12'd1200, 12'd3000, 12'd2800,
                          32'd60000, 16'd50, 16'd2000};
    tank_st           = MODE_NORMAL;
    valve_on          = 1'b0;
    valve_start_ms    = '0;
    fault_latched     = 1'b0;
    manual_on         = '{1'b0, 1'b0};
    btn_last          = '{1'b0, 1'b0, 1'b0};
    press_start_ms    = '{32'd0, 32'd0, 32'd0};
    press_done        = '{1'b0, 1'b0};
    silenced          = 1'b0;
    beep              = 1'b0;
    beep_start_ms     = '0;
    sensor_fault_last = 1'b0;
    walk_ms           = '0;
    walk_level        = 2000;
    walk_up           = 1'b0;
    walk_btn_a        = 1'b0;
    walk_btn_b        = 1'b0;
    walk_btn_alarm    = 1'b0;
    walk_ok           = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk through the reset settings
    add_sample(32'd0,     0,    0,    2000, 0, 1, 0, 0, 0);
    add_sample(32'd100,   4095, 4095, 2000, 0, 1, 0, 0, 0); // both dry
    add_sample(32'd200,   4095, 2499, 2000, 1, 1, 0, 0, 0); // rain blocks pumps
    add_sample(32'd300,   2500, 0,    4095, 0, 1, 0, 0, 0); // full
    add_sample(32'd400,   0,    0,    2799, 0, 1, 0, 0, 0); // back to normal
    add_sample(32'd500,   0,    0,    0,    0, 1, 0, 0, 0); // low, valve opens
    add_sample(32'd1100,  0,    0,    500,  0, 1, 0, 0, 1); // alarm pressed
    add_sample(32'd1200,  0,    0,    500,  0, 1, 0, 0, 0); // short press silences
    add_sample(32'd1300,  0,    0,    900,  0, 1, 1, 0, 0);
    add_sample(32'd1360,  0,    0,    1000, 0, 1, 1, 0, 0); // manual a toggles
    add_sample(32'd1400,  0,    0,    1199, 0, 1, 0, 0, 0);
    add_sample(32'd61500, 0,    0,    1100, 0, 1, 0, 0, 0); // fill timeout
    add_sample(32'd62000, 0,    0,    1100, 0, 1, 0, 0, 1);
    add_sample(32'd64500, 0,    0,    1100, 0, 1, 0, 0, 0); // long press clears
    add_sample(32'd64600, 0,    0,    1200, 0, 1, 0, 0, 0); // normal again
    add_sample(32'd64700, 3000, 3000, 2000, 0, 0, 0, 1, 0); // sensor fault
    add_sample(32'd65300, 3000, 3000, 2000, 0, 0, 0, 1, 0); // manual b, beep
    add_sample(32'hffffff00, 0, 0,    3000, 0, 1, 0, 0, 0);
    add_sample(32'hffffffff, 4095, 4095, 3000, 1, 1, 1, 0, 0);
    add_sample(32'h00000031, 4095, 4095, 3000, 1, 1, 1, 0, 0); // wrapped debounce
    add_sample(32'h00000040, 4095, 4095, 4095, 1, 1, 1, 1, 1);
    add_sample(32'h00000080, 0,    0,    0,    0, 0, 0, 0, 0);
    wait_idle();

    // reset values written back with noise in the upper bits
    apply_settings('{12'd2500, 12'd1000, 12'd1200, 12'd3000, 12'd2800,
                     32'd60000, 16'd50, 16'd2000}, 1'b1);
    add_random_samples(100);
    wait_idle();

    // all registers at their maximum
    apply_settings('{12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff,
                     32'hffffffff, 16'hffff, 16'hffff}, 1'b1);
    add_random_samples(50);
    wait_idle();

    // all registers at zero
    apply_settings('0, 1'b0);
    add_random_samples(50);
    wait_idle();

    // crossed thresholds and a long press shorter than the debounce time
    apply_settings('{12'd1800, 12'd3000, 12'd500, 12'd1500, 12'd3500,
                     32'd700, 16'd100, 16'd20}, 1'b0);
    add_random_samples(70);
    wait_idle();

    // zero fill timeout with ordered thresholds
    apply_settings('{12'd2000, 12'd1500, 12'd1800, 12'd2600, 12'd2400,
                     32'd0, 16'd30, 16'd400}, 1'b1);
    add_random_samples(70);
    wait_idle();

    // random ordered settings with short timeouts
    repeat (3) begin
      apply_settings(random_settings(), 1'($urandom_range(0, 1)));
      add_random_samples(70);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/tfpac_pkg.sv
design/tfpac_cfg.sv
design/tfpac_step.sv
design/tank_fill_pump_alarm_controller.sv
verif/tb_tank_fill_pump_alarm_controller.sv
